### hdl/slt_pkg.sv
`default_nettype none
package slt_pkg;

  localparam int TXN_W = 8;
  localparam int KEY_W = 16;
  localparam int ST_W  = 3;

  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  localparam logic [ST_W-1:0] ST_GRANTED    = 3'd0;
  localparam logic [ST_W-1:0] ST_WAITING    = 3'd1;
  localparam logic [ST_W-1:0] ST_RELEASED   = 3'd2;
  localparam logic [ST_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [ST_W-1:0] ST_QUEUE_FULL = 3'd4;
  localparam logic [ST_W-1:0] ST_NOT_HELD   = 3'd5;

  // one queue record as stored in the record ram
  typedef struct packed {
    logic [TXN_W-1:0] txn;
    logic             excl;
    logic             granted;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // directory update strobes
  typedef struct packed {
    logic set_valid;
    logic clr_valid;
    logic wr_cnt;
  } dir_cmd_t;

  // directory lookup flags
  typedef struct packed {
    logic hit;
    logic free_any;
  } dir_stat_t;

endpackage
`default_nettype wire

### hdl/slt_ram.sv
`default_nettype none
module slt_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/slt_dir.sv
`default_nettype none
module slt_dir #(
  parameter int SLOTS = 16,
  parameter int SW    = 4,
  parameter int CW    = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [slt_pkg::KEY_W-1:0]   lookup_key,
  input  wire slt_pkg::dir_cmd_t           cmd,
  input  wire logic [SW-1:0]               wr_slot,
  input  wire logic [slt_pkg::KEY_W-1:0]   wr_key,
  input  wire logic [CW-1:0]               wr_cnt,
  output      slt_pkg::dir_stat_t          stat,
  output      logic [SW-1:0]               hit_slot,
  output      logic [CW-1:0]               hit_cnt,
  output      logic [SW-1:0]               free_slot
);

  logic [SLOTS-1:0]          valid_r;
  logic [slt_pkg::KEY_W-1:0] key_r [SLOTS];
  logic [CW-1:0]             cnt_r [SLOTS];

  // parallel compare, lowest index wins
  always_comb begin
    stat      = '0;
    hit_slot  = '0;
    hit_cnt   = '0;
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == lookup_key) begin
        stat.hit = 1'b1;
        hit_slot = SW'(i);
        hit_cnt  = cnt_r[i];
      end
      if (!valid_r[i]) begin
        stat.free_any = 1'b1;
        free_slot     = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cmd.set_valid) begin
        valid_r[wr_slot] <= 1'b1;
        key_r[wr_slot]   <= wr_key;
      end
      if (cmd.clr_valid) begin
        valid_r[wr_slot] <= 1'b0;
      end
      if (cmd.wr_cnt) begin
        cnt_r[wr_slot] <= wr_cnt;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/shared_exclusive_lock_table_top.sv
`default_nettype none
// channel | direction | beat contents
// in_     | input     | op, txn, lock_kind, item_key
// out_    | output    | out_txn, out_item, status, last
//
// one request at a time; from accept back to idle a lock walks the records ahead
// of its own (shared requests only), an unlock searches for the granted record,
// closes the gap and rescans the waiters, or stops when no granted record is
// found; the next accept comes once the table is back in idle
// reset (rst_n low, synchronous) empties the slot directory; records need no clear
// the result register frees the request side: a stalled out_ready holds the walk
module shared_exclusive_lock_table_top #(
  parameter int ITEM_SLOTS  = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic                        in_op,
  input  wire logic [slt_pkg::TXN_W-1:0]   in_txn,
  input  wire logic                        in_lock_kind,
  input  wire logic [slt_pkg::KEY_W-1:0]   in_item_key,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [slt_pkg::TXN_W-1:0]   out_txn,
  output      logic [slt_pkg::KEY_W-1:0]   out_item,
  output      logic [slt_pkg::ST_W-1:0]    out_status,
  output      logic                        out_last
);

  localparam int SW = (ITEM_SLOTS > 1) ? $clog2(ITEM_SLOTS) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = SW + PW;
  localparam int RAM_DEPTH = 2 ** AW;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_LRD, S_LEV, S_LFIN, S_URD, S_UEV,
    S_SRD, S_SEV, S_SFIN, S_RRD, S_REV, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // latched request
  logic                      op_r, op_nxt;
  logic [slt_pkg::TXN_W-1:0] txn_r, txn_nxt;
  logic                      kind_r, kind_nxt;
  logic [slt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                      new_slot_r, new_slot_nxt;

  // walk context
  logic [SW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic          ok_r, ok_nxt;

  // held-back result so that last can be set on the final one
  logic [slt_pkg::TXN_W-1:0] pend_txn_r, pend_txn_nxt;
  logic [slt_pkg::ST_W-1:0]  pend_st_r, pend_st_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic [slt_pkg::TXN_W-1:0] out_txn_r, out_txn_nxt;
  logic [slt_pkg::KEY_W-1:0] out_item_r, out_item_nxt;
  logic [slt_pkg::ST_W-1:0]  out_st_r, out_st_nxt;
  logic                      out_last_r, out_last_nxt;

  // directory
  slt_pkg::dir_cmd_t         dcmd;
  slt_pkg::dir_stat_t        dstat;
  logic [SW-1:0]             hit_slot, free_slot;
  logic [CW-1:0]             hit_cnt, dir_cnt;

  // record ram
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  slt_pkg::rec_t             ram_wrec, rd_rec;
  logic [slt_pkg::REC_W-1:0] ram_rdata;

  logic          out_free;
  logic [CW-1:0] j_inc;
  logic          grant;

  assign rd_rec   = slt_pkg::rec_t'(ram_rdata);
  assign out_free = !out_valid_r || out_ready;
  assign j_inc    = CW'(j_r + 1'b1);
  assign in_ready = (state_r == S_IDLE);

  slt_dir #(.SLOTS(ITEM_SLOTS), .SW(SW), .CW(CW)) u_dir (
    .clk        (clk),
    .rst_n      (rst_n),
    .lookup_key (key_r),
    .cmd        (dcmd),
    .wr_slot    (slot_r),
    .wr_key     (key_r),
    .wr_cnt     (dir_cnt),
    .stat       (dstat),
    .hit_slot   (hit_slot),
    .hit_cnt    (hit_cnt),
    .free_slot  (free_slot)
  );

  slt_ram #(.WIDTH(slt_pkg::REC_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrec),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    txn_nxt      = txn_r;
    kind_nxt     = kind_r;
    key_nxt      = key_r;
    new_slot_nxt = new_slot_r;
    slot_nxt     = slot_r;
    cnt_nxt      = cnt_r;
    j_nxt        = j_r;
    ok_nxt       = ok_r;
    pend_txn_nxt = pend_txn_r;
    pend_st_nxt  = pend_st_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_txn_nxt  = out_txn_r;
    out_item_nxt = out_item_r;
    out_st_nxt   = out_st_r;
    out_last_nxt = out_last_r;
    dcmd         = '0;
    dir_cnt      = cnt_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = {slot_r, j_r[PW-1:0]};
    ram_raddr    = {slot_r, j_r[PW-1:0]};
    ram_wrec     = rd_rec;
    grant        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          txn_nxt   = in_txn;
          kind_nxt  = in_lock_kind;
          key_nxt   = in_item_key;
          state_nxt = S_CHK;
        end
      end

      S_CHK: begin
        pend_txn_nxt = txn_r;
        j_nxt        = '0;
        ok_nxt       = 1'b1;
        new_slot_nxt = !dstat.hit;
        slot_nxt     = dstat.hit ? hit_slot : free_slot;
        cnt_nxt      = dstat.hit ? hit_cnt : '0;
        if (op_r == slt_pkg::OP_LOCK) begin
          if (!dstat.hit && !dstat.free_any) begin
            pend_st_nxt = slt_pkg::ST_TABLE_FULL;
            state_nxt   = S_FIN;
          end else if (dstat.hit && hit_cnt >= CW'(QUEUE_DEPTH)) begin
            pend_st_nxt = slt_pkg::ST_QUEUE_FULL;
            state_nxt   = S_FIN;
          end else if (dstat.hit && hit_cnt != '0 && !kind_r) begin
            state_nxt = S_LRD;   // shared: check records ahead
          end else begin
            state_nxt = S_LFIN;
          end
        end else begin
          if (!dstat.hit) begin
            pend_st_nxt = slt_pkg::ST_NOT_HELD;
            state_nxt   = S_FIN;
          end else begin
            state_nxt = S_URD;
          end
        end
      end

      S_LRD: begin
        ram_re    = 1'b1;
        state_nxt = S_LEV;
      end

      S_LEV: begin
        ok_nxt = ok_r && !rd_rec.excl && rd_rec.granted;
        j_nxt  = j_inc;
        state_nxt = (j_inc == cnt_r) ? S_LFIN : S_LRD;
      end

      S_LFIN: begin
        grant          = kind_r ? (cnt_r == '0) : ok_r;
        ram_we         = 1'b1;
        ram_waddr      = {slot_r, cnt_r[PW-1:0]};
        ram_wrec.txn   = txn_r;
        ram_wrec.excl  = kind_r;
        ram_wrec.granted = grant;
        dcmd.set_valid = new_slot_r;
        dcmd.wr_cnt    = 1'b1;
        dir_cnt        = CW'(cnt_r + 1'b1);
        pend_st_nxt    = grant ? slt_pkg::ST_GRANTED : slt_pkg::ST_WAITING;
        state_nxt      = S_FIN;
      end

      S_URD: begin
        ram_re    = 1'b1;
        state_nxt = S_UEV;
      end

      S_UEV: begin
        if (rd_rec.txn == txn_r && rd_rec.granted) begin
          state_nxt = (j_inc < cnt_r) ? S_SRD : S_SFIN;
        end else begin
          j_nxt = j_inc;
          if (j_inc == cnt_r) begin
            pend_st_nxt = slt_pkg::ST_NOT_HELD;
            state_nxt   = S_FIN;
          end else begin
            state_nxt = S_URD;
          end
        end
      end

      // close the gap: move record j+1 down to j
      S_SRD: begin
        ram_re    = 1'b1;
        ram_raddr = {slot_r, j_inc[PW-1:0]};
        state_nxt = S_SEV;
      end

      S_SEV: begin
        ram_we    = 1'b1;
        j_nxt     = j_inc;
        state_nxt = (CW'(j_inc + 1'b1) < cnt_r) ? S_SRD : S_SFIN;
      end

      S_SFIN: begin
        cnt_nxt        = CW'(cnt_r - 1'b1);
        dir_cnt        = CW'(cnt_r - 1'b1);
        dcmd.wr_cnt    = 1'b1;
        dcmd.clr_valid = (cnt_r == CW'(1));
        pend_st_nxt    = slt_pkg::ST_RELEASED;
        j_nxt          = '0;
        ok_nxt         = 1'b1;
        state_nxt      = (cnt_r == CW'(1)) ? S_FIN : S_RRD;
      end

      // rescan for waiters that became compatible
      S_RRD: begin
        ram_re    = 1'b1;
        state_nxt = S_REV;
      end

      S_REV: begin
        grant = !rd_rec.granted && (rd_rec.excl ? (j_r == '0) : ok_r);
        if (!grant || out_free) begin
          if (grant) begin
            ram_we           = 1'b1;
            ram_wrec.granted = 1'b1;
            out_valid_nxt    = 1'b1;
            out_txn_nxt      = pend_txn_r;
            out_item_nxt     = key_r;
            out_st_nxt       = pend_st_r;
            out_last_nxt     = 1'b0;
            pend_txn_nxt     = rd_rec.txn;
            pend_st_nxt      = slt_pkg::ST_GRANTED;
          end
          ok_nxt    = ok_r && !rd_rec.excl && (rd_rec.granted || grant);
          j_nxt     = j_inc;
          state_nxt = (j_inc == cnt_r) ? S_FIN : S_RRD;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_txn_nxt   = pend_txn_r;
          out_item_nxt  = key_r;
          out_st_nxt    = pend_st_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    txn_r      <= txn_nxt;
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    new_slot_r <= new_slot_nxt;
    slot_r     <= slot_nxt;
    cnt_r      <= cnt_nxt;
    j_r        <= j_nxt;
    ok_r       <= ok_nxt;
    pend_txn_r <= pend_txn_nxt;
    pend_st_r  <= pend_st_nxt;
    out_txn_r  <= out_txn_nxt;
    out_item_r <= out_item_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_txn    = out_txn_r;
  assign out_item   = out_item_r;
  assign out_status = out_st_r;
  assign out_last   = out_last_r;

  // a taken request keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open right after accept");

  // a queue never holds more records than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dstat.hit |-> (hit_cnt <= CW'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  // a grant during the rescan follows a result already held back
  a_rescan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REV && ram_we) |-> (pend_st_r == slt_pkg::ST_RELEASED ||
      pend_st_r == slt_pkg::ST_GRANTED))
    else $error("rescan grant without pending result");

endmodule
`default_nettype wire

### tb/shared_exclusive_lock_table_top_tb.sv
`timescale 1ns / 1ps
module shared_exclusive_lock_table_top_tb;

  localparam int SLOTS = 16;
  localparam int DEPTH = 8;
  localparam int STALL_LIMIT = 20000;

  // one expected result beat
  typedef struct packed {
    logic [slt_pkg::TXN_W-1:0] txn;
    logic [slt_pkg::KEY_W-1:0] item;
    logic [slt_pkg::ST_W-1:0]  status;
    logic                      last;
  } grant_beat_t;

  // one request beat
  typedef struct packed {
    logic                      op;
    logic [slt_pkg::TXN_W-1:0] txn;
    logic                      kind;
    logic [slt_pkg::KEY_W-1:0] key;
  } req_t;

  // directed row: request plus optional typed-in status of the single result
  typedef struct packed {
    req_t                     req;
    logic                     has_exp;
    logic [slt_pkg::ST_W-1:0] exp_status;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_op;
  logic [slt_pkg::TXN_W-1:0] in_txn;
  logic in_lock_kind;
  logic [slt_pkg::KEY_W-1:0] in_item_key;
  logic out_valid;
  logic out_ready;
  logic [slt_pkg::TXN_W-1:0] out_txn;
  logic [slt_pkg::KEY_W-1:0] out_item;
  logic [slt_pkg::ST_W-1:0] out_status;
  logic out_last;

  shared_exclusive_lock_table_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_txn(in_txn), .in_lock_kind(in_lock_kind),
    .in_item_key(in_item_key),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_txn(out_txn), .out_item(out_item), .out_status(out_status),
    .out_last(out_last)
  );

  // shadow copy of the lock table
  logic                      lt_valid [SLOTS];
  logic [slt_pkg::KEY_W-1:0] lt_key [SLOTS];
  slt_pkg::rec_t             lt_rec [SLOTS][DEPTH];
  int                        lt_cnt [SLOTS];

  grant_beat_t pending_beats[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit may_grant(int s, int pos);
    if (lt_rec[s][pos].excl) return pos == 0;
    for (int j = 0; j < pos; j++)
      if (lt_rec[s][j].excl || !lt_rec[s][j].granted) return 0;
    return 1;
  endfunction

  function automatic void push_beat(logic [slt_pkg::TXN_W-1:0] t,
                                    logic [slt_pkg::KEY_W-1:0] k,
                                    logic [slt_pkg::ST_W-1:0] st, logic lst);
    grant_beat_t b;
    b.txn = t; b.item = k; b.status = st; b.last = lst;
    pending_beats = {pending_beats, b};
  endfunction

  // advance the shadow table by one request and queue its result beats
  function automatic void predict_locks(req_t r);
    int s, f, pos, cnt, first;
    logic [slt_pkg::TXN_W-1:0] woken[$];
    s = -1;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && lt_valid[i] && lt_key[i] == r.key) s = i;
    if (r.op == slt_pkg::OP_LOCK) begin
      if (s < 0) begin
        f = -1;
        for (int i = 0; i < SLOTS; i++)
          if (f < 0 && !lt_valid[i]) f = i;
        if (f < 0) begin
          push_beat(r.txn, r.key, slt_pkg::ST_TABLE_FULL, 1'b1);
          return;
        end
        s = f; lt_valid[s] = 1'b1; lt_key[s] = r.key; lt_cnt[s] = 0;
      end
      if (lt_cnt[s] >= DEPTH) begin
        push_beat(r.txn, r.key, slt_pkg::ST_QUEUE_FULL, 1'b1);
        return;
      end
      pos = lt_cnt[s];
      lt_rec[s][pos].txn = r.txn;
      lt_rec[s][pos].excl = r.kind;
      lt_rec[s][pos].granted = 1'b0;
      lt_cnt[s] = pos + 1;
      if (may_grant(s, pos)) begin
        lt_rec[s][pos].granted = 1'b1;
        push_beat(r.txn, r.key, slt_pkg::ST_GRANTED, 1'b1);
      end else begin
        push_beat(r.txn, r.key, slt_pkg::ST_WAITING, 1'b1);
      end
    end else begin
      if (s < 0) begin
        push_beat(r.txn, r.key, slt_pkg::ST_NOT_HELD, 1'b1);
        return;
      end
      cnt = lt_cnt[s];
      first = -1;
      for (int p = 0; p < cnt; p++)
        if (first < 0 && lt_rec[s][p].txn == r.txn && lt_rec[s][p].granted) first = p;
      if (first < 0) begin
        push_beat(r.txn, r.key, slt_pkg::ST_NOT_HELD, 1'b1);
        return;
      end
      for (int j = first; j + 1 < cnt; j++) lt_rec[s][j] = lt_rec[s][j+1];
      cnt--;
      lt_cnt[s] = cnt;
      for (int j = 0; j < cnt; j++)
        if (!lt_rec[s][j].granted && may_grant(s, j)) begin
          lt_rec[s][j].granted = 1'b1;
          woken = {woken, lt_rec[s][j].txn};
        end
      if (cnt == 0) lt_valid[s] = 1'b0;
      push_beat(r.txn, r.key, slt_pkg::ST_RELEASED, woken.size() == 0);
      foreach (woken[i])
        push_beat(woken[i], r.key, slt_pkg::ST_GRANTED, i == woken.size() - 1);
    end
  endfunction

  // send one request beat, holding it until accepted; valid drops only for idling
  task automatic send_req(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= r.op; in_txn <= r.txn; in_lock_kind <= r.kind; in_item_key <= r.key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_locks(r);
    @(negedge clk);
  endtask

  // typed-in rows already queued their beat; the predictor only tracks state then
  task automatic send_req_checked(row_t row);
    send_req(row.req);
    if (row.has_exp) void'(pending_beats.pop_back());
  endtask

  // receiver: random stall, checks each beat against the oldest expectation
  always @(negedge clk) begin
    out_ready <= rst_n ? ($urandom_range(99) >= recv_idle_pct) : 1'b0;
  end

  always @(posedge clk) begin
    grant_beat_t b;
    if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat txn=%0d item=%0d status=%0d last=%0d",
                 $time, out_txn, out_item, out_status, out_last);
        errors++;
      end else begin
        b = pending_beats.pop_front();
        if (out_txn !== b.txn) begin
          $display("%0t: txn expected %0d actual %0d", $time, b.txn, out_txn);
          errors++;
        end
        if (out_item !== b.item) begin
          $display("%0t: item expected %0d actual %0d", $time, b.item, out_item);
          errors++;
        end
        if (out_status !== b.status) begin
          $display("%0t: status expected %0d actual %0d", $time, b.status, out_status);
          errors++;
        end
        if (out_last !== b.last) begin
          $display("%0t: last expected %0d actual %0d", $time, b.last, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("shared_exclusive_lock_table_top_tb: errors");
      $finish;
    end
  end

  function automatic row_t mk(logic op, logic [slt_pkg::TXN_W-1:0] t, logic kind,
                              logic [slt_pkg::KEY_W-1:0] k, logic has,
                              logic [slt_pkg::ST_W-1:0] st);
    row_t r;
    r.req.op = op; r.req.txn = t; r.req.kind = kind; r.req.key = k;
    r.has_exp = has; r.exp_status = st;
    return r;
  endfunction

  // random key from a small pool so queues build up; occasionally anything
  function automatic logic [slt_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(19) == 0) return slt_pkg::KEY_W'($urandom_range(16'hffff));
    return slt_pkg::KEY_W'(16'h1000 + $urandom_range(19));
  endfunction

  task automatic run_random(int n);
    req_t r;
    for (int i = 0; i < n; i++) begin
      r.txn = ($urandom_range(9) == 0) ? slt_pkg::TXN_W'($urandom_range(255))
                                       : slt_pkg::TXN_W'($urandom_range(7));
      r.key = pick_key();
      r.kind = 1'($urandom_range(1));
      r.op = ($urandom_range(99) < 45) ? slt_pkg::OP_UNLOCK : slt_pkg::OP_LOCK;
      send_req(r);
    end
  endtask

  row_t rows[$];

  initial begin
    req_t r;
    rst_n = 1'b0;
    in_valid = 1'b0; in_op = slt_pkg::OP_LOCK; in_txn = '0; in_lock_kind = 1'b0;
    in_item_key = '0;
    for (int i = 0; i < SLOTS; i++) begin
      lt_valid[i] = 1'b0; lt_cnt[i] = 0; lt_key[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // unlock on empty table, extremes of fields, shared/exclusive mixing
    rows = {rows, mk(slt_pkg::OP_UNLOCK, 8'd0, 1'b0, 16'h0000, 1'b1, slt_pkg::ST_NOT_HELD)};
    rows = {rows, mk(slt_pkg::OP_LOCK, 8'hff, 1'b1, 16'hffff, 1'b1, slt_pkg::ST_GRANTED)};
    rows = {rows, mk(slt_pkg::OP_LOCK, 8'h00, 1'b0, 16'hffff, 1'b1, slt_pkg::ST_WAITING)};
    rows = {rows, mk(slt_pkg::OP_LOCK, 8'h01, 1'b0, 16'hffff, 1'b0, slt_pkg::ST_WAITING)};
    rows = {rows, mk(slt_pkg::OP_LOCK, 8'h02, 1'b1, 16'hffff, 1'b0, slt_pkg::ST_WAITING)};
    // waiter unlock is refused
    rows = {rows, mk(slt_pkg::OP_UNLOCK, 8'h00, 1'b0, 16'hffff, 1'b1, slt_pkg::ST_NOT_HELD)};
    // release wakes two shared waiters
    rows = {rows, mk(slt_pkg::OP_UNLOCK, 8'hff, 1'b0, 16'hffff, 1'b0, slt_pkg::ST_RELEASED)};
    rows = {rows, mk(slt_pkg::OP_LOCK, 8'h00, 1'b0, 16'h0000, 1'b1, slt_pkg::ST_GRANTED)};
    rows = {rows, mk(slt_pkg::OP_LOCK, 8'h00, 1'b0, 16'h0000, 1'b1, slt_pkg::ST_GRANTED)};
    rows = {rows, mk(slt_pkg::OP_UNLOCK, 8'h00, 1'b1, 16'h0000, 1'b0, slt_pkg::ST_RELEASED)};
    rows = {rows, mk(slt_pkg::OP_UNLOCK, 8'h01, 1'b0, 16'hffff, 1'b0, slt_pkg::ST_RELEASED)};
    rows = {rows, mk(slt_pkg::OP_UNLOCK, 8'h00, 1'b0, 16'hffff, 1'b0, slt_pkg::ST_RELEASED)};
    rows = {rows, mk(slt_pkg::OP_UNLOCK, 8'h02, 1'b0, 16'hffff, 1'b0, slt_pkg::ST_RELEASED)};
    rows = {rows, mk(slt_pkg::OP_UNLOCK, 8'h00, 1'b0, 16'h0000, 1'b0, slt_pkg::ST_RELEASED)};
    foreach (rows[i]) begin
      if (rows[i].has_exp) push_beat(rows[i].req.txn, rows[i].req.key,
                                      rows[i].exp_status, 1'b1);
      send_req_checked(rows[i]);
    end

    // queue full on one key, then fill the table to overflow
    for (int i = 0; i < DEPTH + 1; i++) begin
      r.op = slt_pkg::OP_LOCK; r.txn = slt_pkg::TXN_W'(i); r.kind = 1'b0;
      r.key = 16'h5555; send_req(r);
    end
    for (int i = 0; i < SLOTS; i++) begin
      r.op = slt_pkg::OP_LOCK; r.txn = 8'h80; r.kind = 1'b1;
      r.key = slt_pkg::KEY_W'(16'h6000 + i); send_req(r);
    end
    for (int i = 0; i < DEPTH; i++) begin
      r.op = slt_pkg::OP_UNLOCK; r.txn = slt_pkg::TXN_W'(i); r.kind = 1'b0;
      r.key = 16'h5555; send_req(r);
    end
    for (int i = 0; i < SLOTS - 1; i++) begin
      r.op = slt_pkg::OP_UNLOCK; r.txn = 8'h80; r.kind = 1'b0;
      r.key = slt_pkg::KEY_W'(16'h6000 + i); send_req(r);
    end

    // random phases with different idling mixes
    send_idle_pct = 7;  recv_idle_pct = 82; run_random(106);
    send_idle_pct = 82; recv_idle_pct = 7;  run_random(106);
    send_idle_pct = 0;  recv_idle_pct = 0;  run_random(106);
    in_valid <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("shared_exclusive_lock_table_top_tb: clean");
    else $display("shared_exclusive_lock_table_top_tb: errors");
    $finish;
  end

endmodule
